// ----- design/asld_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the adaptive sound level detector.
// Used by asld_div_cell, adaptive_sound_level_detector and the testbench; depends on nothing.
package asld_pkg;

  localparam int THR_W   = 12;
  localparam int STEP_W  = 12;
  localparam int LVL_W   = 4;
  localparam int COOL_W  = 16;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 16;
  localparam int QUO_W   = LVL_W + 1;
  localparam int OUT_DW  = 8;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 12'd150;
  localparam logic [STEP_W-1:0] STEP_RST      = 12'd30;
  localparam logic [LVL_W-1:0]  MAX_LEVEL_RST = 4'd5;
  localparam logic [COOL_W-1:0] COOLDOWN_RST  = 16'd200;

  typedef enum logic [CFG_AW-1:0] {
    REG_THRESHOLD,
    REG_STEP_SIZE,
    REG_MAX_LEVEL,
    REG_COOLDOWN
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic             dropped;
    logic             detected;
    logic [LVL_W-1:0] level;
  } result_t;

endpackage

// ----- design/adaptive_sound_level_detector.sv -----
`timescale 1ns / 1ps
// Top level of the adaptive sound level detector: ring of background samples,
// running sum, threshold test and a chain of quotient cells. Depends on asld_pkg and asld_div_cell.
//
//  Channel  | Signals                              | Content
//  ---------+--------------------------------------+--------------------------------
//  input    | s_axis_tvalid/tready/tdata           | one ADC sample per transaction
//  output   | m_axis_tvalid/tready/tdata           | level, detected, dropped
//  config   | cfg_we, cfg_addr, cfg_data           | one register write per cycle
//
// A priming, cool-down or noise sample passes the accept, evaluate and output states.
// A detection also passes the divide state, where it runs through the five registered quotient cells.
// Reset is synchronous and clears all control state; the ring needs no clearing.
// A stalled output holds the block in its output state until the result is taken.
module adaptive_sound_level_detector
  import asld_pkg::*;
#(
  parameter int RING_DEPTH  = 400,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // Bits from the lowest: sample, then zero fill.
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // Bits from the lowest: level (4), detected (1), dropped (1), zero fill (2).
  output logic [OUT_DW-1:0]                     m_axis_tdata,
  input  logic                                  cfg_we,
  input  logic [CFG_AW-1:0]                     cfg_addr,
  input  logic [CFG_DW-1:0]                     cfg_data
);

  localparam int AW       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int PRIME_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W    = SAMPLE_BITS + AW;
  localparam int RSH      = SUM_W + AW;
  localparam int RECIP_W  = SUM_W + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RSH) + longint'(RING_DEPTH) - 1) / longint'(RING_DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int CMP_W    = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 1;
  localparam int DIV_W    = (SAMPLE_BITS > STEP_W + QUO_W - 1) ? SAMPLE_BITS
                                                                : STEP_W + QUO_W - 1;

  logic [THR_W-1:0]       threshold;
  logic [STEP_W-1:0]      step_size;
  logic [LVL_W-1:0]       max_level;
  logic [COOL_W-1:0]      cooldown_samples;

  state_t                 state;
  state_t                 state_next;
  logic [SUM_W-1:0]       bg_sum;
  logic [AW-1:0]          ring_pos;
  logic [PRIME_W-1:0]     prime_cnt;
  logic [COOL_W-1:0]      cool_left;
  logic [LVL_W-1:0]       held_level;
  logic [SAMPLE_BITS-1:0] sample;
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] ring_rdata;
  result_t                res;
  result_t                out_res;
  logic                   out_valid;

  logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];

  logic                   in_acc;
  logic                   priming;
  logic                   cooling;
  logic                   is_det;
  logic [SAMPLE_BITS-1:0] avg;
  logic [CMP_W-1:0]       thr_sum;
  logic [CMP_W-1:0]       excess;
  logic                   out_free;
  logic                   eval_en;
  logic                   div_start;
  logic                   div_take;
  logic                   out_load;
  logic                   ring_we;
  logic [AW-1:0]          ring_waddr;
  logic [LVL_W-1:0]       det_level;

  logic                   chain_valid [QUO_W+1];
  logic [DIV_W-1:0]       chain_rem   [QUO_W+1];
  logic [QUO_W-1:0]       chain_quo   [QUO_W+1];

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign priming  = (prime_cnt < PRIME_W'(RING_DEPTH));
  assign cooling  = (cool_left != '0);
  assign avg      = prod[RSH +: SAMPLE_BITS];
  assign thr_sum  = CMP_W'(avg) + CMP_W'(threshold);
  assign is_det   = (CMP_W'(sample) >= thr_sum);
  assign excess   = CMP_W'(sample) - thr_sum;
  assign out_free = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_DW'(out_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold        <= THRESHOLD_RST;
      step_size        <= STEP_RST;
      max_level        <= MAX_LEVEL_RST;
      cooldown_samples <= COOLDOWN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_THRESHOLD: threshold        <= cfg_data[THR_W-1:0];
        REG_STEP_SIZE: step_size        <= cfg_data[STEP_W-1:0];
        REG_MAX_LEVEL: max_level        <= cfg_data[LVL_W-1:0];
        REG_COOLDOWN:  cooldown_samples <= cfg_data[COOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (priming || cooling || !is_det) state_next = ST_OUTPUT;
        else state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (chain_valid[QUO_W]) state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    eval_en       = 1'b0;
    div_start     = 1'b0;
    div_take      = 1'b0;
    out_load      = 1'b0;
    case (state)
      ST_IDLE:   s_axis_tready = !rst;
      ST_EVAL: begin
        eval_en   = 1'b1;
        div_start = !priming && !cooling && is_det;
      end
      ST_DIVIDE: div_take = chain_valid[QUO_W];
      ST_OUTPUT: out_load = out_free;
      default: ;
    endcase
  end

  assign ring_we    = eval_en && (priming || (!cooling && !is_det));
  assign ring_waddr = priming ? prime_cnt[AW-1:0] : ring_pos;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_waddr] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring_rdata <= ring[ring_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample <= s_axis_tdata[SAMPLE_BITS-1:0];
      prod   <= bg_sum * RECIP;
    end
  end

  assign det_level = (chain_quo[QUO_W] > QUO_W'(max_level)) ? max_level
                                                           : chain_quo[QUO_W][LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      bg_sum     <= '0;
      ring_pos   <= '0;
      prime_cnt  <= '0;
      cool_left  <= '0;
      held_level <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (eval_en) begin
        if (priming) begin
          bg_sum    <= bg_sum + SUM_W'(sample);
          prime_cnt <= prime_cnt + PRIME_W'(1);
        end else if (cooling) begin
          cool_left <= cool_left - COOL_W'(1);
        end else if (!is_det) begin
          bg_sum     <= bg_sum - SUM_W'(ring_rdata) + SUM_W'(sample);
          ring_pos   <= (ring_pos == AW'(RING_DEPTH - 1)) ? '0 : ring_pos + AW'(1);
          held_level <= '0;
        end
      end
      if (div_take) begin
        held_level <= det_level;
        cool_left  <= cooldown_samples;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval_en) begin
      res.dropped  <= priming || cooling;
      res.detected <= 1'b0;
      res.level    <= (!priming && cooling) ? held_level : '0;
    end else if (div_take) begin
      res.dropped  <= 1'b0;
      res.detected <= 1'b1;
      res.level    <= det_level;
    end
    if (out_load) begin
      out_res <= res;
    end
  end

  assign chain_valid[0] = div_start;
  assign chain_rem[0]   = DIV_W'(excess);
  assign chain_quo[0]   = '0;

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    asld_div_cell #(
      .DIV_W (DIV_W),
      .SHIFT (QUO_W - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_rem    (chain_rem[i]),
      .in_quo    (chain_quo[i]),
      .step      (step_size),
      .out_valid (chain_valid[i+1]),
      .out_rem   (chain_rem[i+1]),
      .out_quo   (chain_quo[i+1])
    );
  end

endmodule

// ----- design/asld_div_cell.sv -----
`timescale 1ns / 1ps
// One cell of the quotient chain: a registered restoring-division step for one bit.
// Depends on asld_pkg.
module asld_div_cell
  import asld_pkg::*;
#(
  parameter int DIV_W = 16,
  parameter int SHIFT = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DIV_W-1:0]  in_rem,
  input  logic [QUO_W-1:0]  in_quo,
  input  logic [STEP_W-1:0] step,
  output logic              out_valid,
  output logic [DIV_W-1:0]  out_rem,
  output logic [QUO_W-1:0]  out_quo
);

  logic [DIV_W-1:0] shifted;
  logic             fits;

  assign shifted = DIV_W'(step) << SHIFT;
  assign fits    = (in_rem >= shifted);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem <= fits ? (in_rem - shifted) : in_rem;
    out_quo <= {in_quo[QUO_W-2:0], fits};
  end

endmodule

// ----- tb/adaptive_sound_level_detector_checker.sv -----
`timescale 1ns / 1ps
// Checker of the adaptive sound level detector. It watches the sample, result and register
// write channels, predicts every result and compares it field by field. Depends on asld_pkg.
module adaptive_sound_level_detector_checker
  import asld_pkg::*;
#(
  parameter int RING_DEPTH = 400
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  // Bits from the lowest: sample (12), zero fill (4).
  input  logic [15:0]       s_axis_tdata,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // Bits from the lowest: level (4), detected (1), dropped (1), zero fill (2).
  input  logic [OUT_DW-1:0] m_axis_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data,
  output int                results_pending,
  output logic [11:0]       bg_average,
  output int                mismatches
);

  logic [THR_W-1:0]  threshold;
  logic [STEP_W-1:0] step_size;
  logic [LVL_W-1:0]  max_level;
  logic [COOL_W-1:0] cooldown_len;

  logic [11:0]       bg_ring [RING_DEPTH];
  int unsigned       bg_sum;
  int unsigned       ring_pos;
  int unsigned       primed;
  int unsigned       cooldown_left;
  logic [LVL_W-1:0]  held_level;
  int                errs;
  result_t           awaited_results [$];

  function automatic result_t classify_sample(input logic [11:0] smp);
    result_t     res;
    int unsigned avg;
    int unsigned excess;
    int unsigned quot;
    res = '0;
    if (primed < RING_DEPTH) begin
      bg_ring[primed] = smp;
      bg_sum += smp;
      primed++;
      res.dropped = 1'b1;
    end else if (cooldown_left > 0) begin
      cooldown_left--;
      res.level = held_level;
      res.dropped = 1'b1;
    end else begin
      avg = bg_sum / RING_DEPTH;
      if (smp >= avg + threshold) begin
        excess = smp - avg - threshold;
        if (step_size == 0) begin
          res.level = max_level;
        end else begin
          quot = excess / step_size;
          res.level = (quot > max_level) ? max_level : quot[LVL_W-1:0];
        end
        held_level = res.level;
        cooldown_left = cooldown_len;
        res.detected = 1'b1;
      end else begin
        bg_sum = bg_sum - bg_ring[ring_pos] + smp;
        bg_ring[ring_pos] = smp;
        ring_pos = (ring_pos + 1) % RING_DEPTH;
        held_level = '0;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      threshold = THRESHOLD_RST;
      step_size = STEP_RST;
      max_level = MAX_LEVEL_RST;
      cooldown_len = COOLDOWN_RST;
      bg_sum = 0;
      ring_pos = 0;
      primed = 0;
      cooldown_left = 0;
      held_level = '0;
      errs = 0;
      awaited_results.delete();
      mismatches <= 0;
      results_pending <= 0;
      bg_average <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_THRESHOLD: threshold = cfg_data[THR_W-1:0];
          REG_STEP_SIZE: step_size = cfg_data[STEP_W-1:0];
          REG_MAX_LEVEL: max_level = cfg_data[LVL_W-1:0];
          REG_COOLDOWN:  cooldown_len = cfg_data[COOL_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_results.push_back(classify_sample(s_axis_tdata[11:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[5:0];
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none awaited: expected nothing, actual %h", $time, got);
          errs++;
        end else begin
          want = awaited_results.pop_front();
          if (got.level !== want.level) begin
            $display("%0t: level mismatch: expected %0d, actual %0d",
                     $time, want.level, got.level);
            errs++;
          end
          if (got.detected !== want.detected) begin
            $display("%0t: detected mismatch: expected %0b, actual %0b",
                     $time, want.detected, got.detected);
            errs++;
          end
          if (got.dropped !== want.dropped) begin
            $display("%0t: dropped mismatch: expected %0b, actual %0b",
                     $time, want.dropped, got.dropped);
            errs++;
          end
        end
      end
      mismatches <= errs;
      results_pending <= awaited_results.size();
      bg_average <= 12'(bg_sum / RING_DEPTH);
    end
  end

endmodule

// ----- tb/adaptive_sound_level_detector_test.sv -----
`timescale 1ns / 1ps
// Top of the adaptive sound level detector testbench: clock, reset, sample stimulus,
// register programming and the verdict. Depends on asld_pkg, the block and its checker.
module adaptive_sound_level_detector_test;
  import asld_pkg::*;

  localparam int RING_DEPTH    = 400;
  localparam int SAMPLE_MAX    = 4095;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // Bits from the lowest: sample (12), zero fill (4).
  logic [15:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // Bits from the lowest: level (4), detected (1), dropped (1), zero fill (2).
  logic [OUT_DW-1:0] m_axis_tdata;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  int                results_pending;
  int                mismatches;
  logic [11:0]       bg_average;
  int                gap_pct = 0;
  int                stall_pct = 0;
  int                quiet_cycles = 0;

  adaptive_sound_level_detector #(
    .RING_DEPTH (RING_DEPTH),
    .SAMPLE_BITS(12)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data)
  );

  adaptive_sound_level_detector_checker #(
    .RING_DEPTH(RING_DEPTH)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .results_pending(results_pending),
    .bg_average     (bg_average),
    .mismatches     (mismatches)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("adaptive_sound_level_detector verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [11:0] to_sample(input int value);
    if (value < 0) return '0;
    if (value > SAMPLE_MAX) return 12'(SAMPLE_MAX);
    return 12'(value);
  endfunction

  // Valid stays high between back-to-back transactions and is lowered only in a gap.
  task automatic push_sample(input logic [11:0] smp);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0000, smp};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_results_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  task automatic program_regs(input int thr, input int step, input int mx, input int cool);
    cfg_we <= 1'b1;
    cfg_addr <= REG_THRESHOLD;
    cfg_data <= CFG_DW'(thr);
    @(posedge clk);
    cfg_addr <= REG_STEP_SIZE;
    cfg_data <= CFG_DW'(step);
    @(posedge clk);
    cfg_addr <= REG_MAX_LEVEL;
    cfg_data <= CFG_DW'(mx);
    @(posedge clk);
    cfg_addr <= REG_COOLDOWN;
    cfg_data <= CFG_DW'(cool);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Settles the block first so that the background average is exact.
  task automatic send_near_average(input int offset);
    wait_results_idle();
    push_sample(to_sample(int'(bg_average) + offset));
  endtask

  task automatic run_random_phase(input int thr, input int step, input int mx, input int cool,
                                  input int gap, input int stall, input int count);
    int pick;
    int offset;
    wait_results_idle();
    program_regs(thr, step, mx, cool);
    gap_pct = gap;
    stall_pct = stall;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        offset = int'($urandom_range(thr + 149)) - 150;
      end else if (pick < 85) begin
        offset = thr + int'($urandom_range(step * (mx + 2)));
      end else begin
        offset = int'($urandom_range(SAMPLE_MAX)) - int'(bg_average);
      end
      push_sample(to_sample(int'(bg_average) + offset));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    gap_pct = 12;
    stall_pct = 12;
    push_sample(12'd0);
    push_sample(12'(SAMPLE_MAX));
    repeat (RING_DEPTH - 2) begin
      if ($urandom_range(9) == 0) begin
        push_sample(12'($urandom_range(SAMPLE_MAX)));
      end else begin
        push_sample(12'($urandom_range(800, 200)));
      end
    end

    gap_pct = 0;
    stall_pct = 0;
    wait_results_idle();
    program_regs(150, 30, 5, 3);
    send_near_average(0);
    send_near_average(149);
    send_near_average(150);
    send_near_average(SAMPLE_MAX);
    send_near_average(-SAMPLE_MAX);
    send_near_average(0);
    send_near_average(180);
    repeat (3) send_near_average(0);
    send_near_average(SAMPLE_MAX);
    repeat (3) send_near_average(SAMPLE_MAX);
    send_near_average(-SAMPLE_MAX);

    // A zero step saturates the level; a zero cool-down lets the next sample detect at once.
    wait_results_idle();
    program_regs(150, 0, 7, 0);
    send_near_average(155);
    send_near_average(150);
    send_near_average(-1);

    wait_results_idle();
    program_regs(0, 1, 15, 1);
    send_near_average(SAMPLE_MAX);
    send_near_average(0);
    send_near_average(0);
    send_near_average(0);
    send_near_average(-1);

    run_random_phase(150, 30, 5, 4, 0, 0, 150);
    run_random_phase(60, 7, 15, 0, 63, 0, 150);
    run_random_phase(300, 100, 3, 8, 0, 63, 150);
    run_random_phase(SAMPLE_MAX, SAMPLE_MAX, 0, 65535, 12, 12, 40);
    run_random_phase(0, 1, 15, 2, 12, 12, 80);
    run_random_phase($urandom_range(400, 20), $urandom_range(200, 1), $urandom_range(15),
                     $urandom_range(6), 0, 0, 130);

    wait_results_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("adaptive_sound_level_detector verification clean");
    end else begin
      $display("adaptive_sound_level_detector verification failed");
    end
    $finish;
  end

endmodule
